### src/lbgc_pkg.sv
// Package for the bump-and-go controller: constants, mode codes, register indexes.
// No dependencies.
`default_nettype none
package lbgc_pkg;
  localparam int MaxKept = 1024;
  localparam int BankW = $clog2(MaxKept);
  localparam int CntW = BankW + 1;
  localparam int AddrW = BankW + 1;
  localparam logic [13:0] EmptyMean = 14'd10000;

  typedef enum logic [1:0] {
    MODE_FWD   = 2'd0,
    MODE_BACK  = 2'd1,
    MODE_LEFT  = 2'd2,
    MODE_RIGHT = 2'd3
  } mode_t;

  localparam logic [2:0] REG_RANGE_MIN = 3'd0;
  localparam logic [2:0] REG_DETECT    = 3'd1;
  localparam logic [2:0] REG_BACK      = 3'd2;
  localparam logic [2:0] REG_TURN      = 3'd3;
  localparam logic [2:0] REG_LINEAR    = 3'd4;
  localparam logic [2:0] REG_ANGULAR   = 3'd5;
  localparam logic [2:0] REG_WIN_LOW   = 3'd6;
  localparam logic [2:0] REG_WIN_HIGH  = 3'd7;

  // Sequencer states (one-hot)
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_DEC  = 5'b01000,
    ST_OUT  = 5'b10000
  } seq_t;
endpackage
`default_nettype wire

### src/lbgc_div.sv
// Iterative restoring divider: 32-bit sum by 16-bit count, one quotient bit per cycle.
// Depends on lbgc_pkg.
`default_nettype none
module lbgc_div
  import lbgc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [5:0]  count;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [15:0] dvs;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {17'd0, dvs};
  assign quotient = quo;

  // Shift one bit a cycle, subtract when the trial does not go negative
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd32;
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### src/laser_bump_and_go_controller_unit.sv
// Laser bump-and-go controller: ping-pong scan store and four-mode sequencer; uses lbgc_pkg, lbgc_div.
// Sample requests are taken one per cycle, back to back, while the sequencer is idle, and give no result.
// A forward step walks the committed scan of n entries, runs two divisions and decides.
// Other steps set their result and pass through ST_OUT, where it is loaded into the output register.
// Further requests are taken only once the sequencer is back in ST_IDLE.
// A result not taken stalls only the sequencer. Sync reset clears control state, not the store.
`default_nettype none
module laser_bump_and_go_controller_unit
  import lbgc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // sample_index[11:0], distance_mm[27:12], zero fill
  input  wire logic        s_tuser,   // kind
  input  wire logic        s_tlast,   // last_sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // linear_cmd[10:0], angular_cmd[23:11],
                                      // motion_mode[25:24], left[26], right[27]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  // Configuration registers
  logic [15:0] range_min, detect, back_steps, turn_steps;
  logic [9:0]  linear;
  logic [11:0] angular, win_low, win_high;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= 16'd150; detect <= 16'd750; back_steps <= 16'd20;
      turn_steps <= 16'd20; linear <= 10'd200; angular <= 12'd600;
      win_low <= 12'd0; win_high <= 12'd4095;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RANGE_MIN: range_min <= pwdata[15:0];
        REG_DETECT:    detect <= pwdata[15:0];
        REG_BACK:      back_steps <= pwdata[15:0];
        REG_TURN:      turn_steps <= pwdata[15:0];
        REG_LINEAR:    linear <= pwdata[9:0];
        REG_ANGULAR:   angular <= pwdata[11:0];
        REG_WIN_LOW:   win_low <= pwdata[11:0];
        REG_WIN_HIGH:  win_high <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RANGE_MIN: prdata = {16'd0, range_min};
      REG_DETECT:    prdata = {16'd0, detect};
      REG_BACK:      prdata = {16'd0, back_steps};
      REG_TURN:      prdata = {16'd0, turn_steps};
      REG_LINEAR:    prdata = {22'd0, linear};
      REG_ANGULAR:   prdata = {20'd0, angular};
      REG_WIN_LOW:   prdata = {20'd0, win_low};
      REG_WIN_HIGH:  prdata = {20'd0, win_high};
      default:       prdata = '0;
    endcase
  end

  // Scan store and control state
  logic [15:0] store [0:2*MaxKept-1];
  logic [15:0] rd_data;
  logic [AddrW-1:0] rd_addr;
  logic        bank;
  logic [CntW-1:0] committed, fill;
  mode_t       mode;
  logic        lmark, rmark;
  logic [15:0] timer;
  seq_t        st;

  logic [11:0] in_idx;
  logic [15:0] in_dist;
  logic        take, keep;
  logic        m_tvalid_hold;
  assign m_tvalid_hold = m_tvalid && !m_tready;
  assign in_idx  = s_tdata[11:0];
  assign in_dist = s_tdata[27:12];
  assign s_tready = (st == ST_IDLE);
  assign take = s_tvalid && s_tready;
  assign keep = ((in_idx < win_low) || (in_idx >= win_high)) && (fill < CntW'(MaxKept));

  // Write kept samples into the filling bank
  always_ff @(posedge clk) begin
    if (take && !s_tuser && keep)
      store[{bank, fill[BankW-1:0]}] <= in_dist;
    rd_data <= store[rd_addr];
  end

  // Scan walk bookkeeping
  logic [CntW-1:0] rd_cnt;       // entries issued
  logic            rd_vld;       // rd_data valid this cycle
  logic            rd_left;      // entry belongs to left half
  logic [CntW-1:0] half;
  logic [31:0] sum_r, sum_l;
  logic [15:0] cnt_r, cnt_l;
  logic        div_start, div_done, div_sel;
  logic [31:0] div_q;
  logic [15:0] mean_r, mean_l;
  logic [16:0] up_gate, r2;
  logic        in_gate;
  logic        scan_end;

  assign half = committed >> 1;
  assign rd_addr = {~bank, rd_cnt[BankW-1:0]};
  assign up_gate = {1'b0, detect} + {2'b0, detect[15:1]};
  assign r2 = {1'b0, rd_data};
  // 2r <= 3d  <=>  r <= d + d/2 (integer r)
  assign in_gate = (rd_data >= range_min) && (r2 <= up_gate);
  assign scan_end = (!rd_vld && (rd_cnt >= committed) && (rd_cnt != '0)) || (committed == '0);

  lbgc_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(div_sel ? sum_l : sum_r),
    .divisor(div_sel ? cnt_l : cnt_r),
    .done(div_done), .quotient(div_q)
  );

  logic lm, rm, lsel, rsel;
  logic [15:0] timer_inc;
  logic [10:0] res_lin;
  logic [12:0] res_ang;
  mode_t       res_mode;
  logic        load;
  assign timer_inc = (timer == 16'hFFFF) ? timer : timer + 16'd1;
  assign lm = mean_l < detect;
  assign rm = mean_r < detect;
  assign lsel = lm && !(rm && !(mean_l < mean_r));
  assign rsel = rm && !(lm && (mean_l < mean_r));
  assign load = ((st == ST_DEC) || (st == ST_OUT)) && !m_tvalid_hold;

  // Output register: load a finished result once the previous one has gone
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      m_tdata <= (st == ST_DEC) ? {4'd0, rsel, lsel, res_mode, res_ang, res_lin}
                                : {4'd0, rmark, lmark, res_mode, res_ang, res_lin};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE; bank <= 1'b0; committed <= '0; fill <= '0;
      mode <= MODE_FWD; lmark <= 1'b0; rmark <= 1'b0; timer <= '0;
      rd_cnt <= '0; rd_vld <= 1'b0; div_start <= 1'b0;
      div_sel <= 1'b0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (take && !s_tuser) begin
            // Store sample, commit on last
            if (s_tlast) begin
              committed <= keep ? fill + 1'b1 : fill;
              bank <= ~bank;
              fill <= '0;
            end else if (keep) begin
              fill <= fill + 1'b1;
            end
          end else if (take) begin
            res_mode <= mode;
            if (mode == MODE_FWD) begin
              res_lin <= {1'b0, linear};
              res_ang <= '0;
              sum_r <= '0; sum_l <= '0; cnt_r <= '0; cnt_l <= '0;
              rd_cnt <= '0; rd_vld <= 1'b0;
              st <= ST_SCAN;
            end else begin
              if (mode == MODE_BACK) begin
                res_lin <= -{1'b0, linear};
                res_ang <= '0;
                timer <= (timer_inc >= back_steps) ? '0 : timer_inc;
                if (timer_inc >= back_steps)
                  mode <= lmark ? MODE_RIGHT : MODE_LEFT;
              end else begin
                res_lin <= '0;
                res_ang <= (mode == MODE_LEFT) ? {1'b0, angular} : -{1'b0, angular};
                timer <= (timer_inc >= turn_steps) ? '0 : timer_inc;
                if (timer_inc >= turn_steps)
                  mode <= MODE_FWD;
              end
              st <= ST_OUT;
            end
          end
        end
        ST_SCAN: begin
          // Issue one read a cycle, accumulate the previous one
          rd_vld <= rd_cnt < committed;
          rd_left <= rd_cnt >= half;
          if (rd_cnt < committed) rd_cnt <= rd_cnt + 1'b1;
          if (rd_vld && in_gate) begin
            if (rd_left) begin
              sum_l <= sum_l + {16'd0, rd_data}; cnt_l <= cnt_l + 16'd1;
            end else begin
              sum_r <= sum_r + {16'd0, rd_data}; cnt_r <= cnt_r + 16'd1;
            end
          end
          div_start <= scan_end;
          if (scan_end) begin
            div_sel <= 1'b0; st <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_start <= div_done && !div_sel;
          if (div_done) begin
            if (!div_sel) begin
              mean_r <= (cnt_r == 0) ? 16'(EmptyMean) : div_q[15:0];
              div_sel <= 1'b1;
            end else begin
              mean_l <= (cnt_l == 0) ? 16'(EmptyMean) : div_q[15:0];
              st <= ST_DEC;
            end
          end
        end
        ST_DEC: begin
          // Hold the decision until the output register is free
          if (!m_tvalid_hold) begin
            lmark <= lsel;
            rmark <= rsel;
            if (lm || rm) begin
              mode <= MODE_BACK; timer <= '0;
            end
            st <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (!m_tvalid_hold) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/lbgc_checker.sv
// Port-level checker for the bump-and-go controller, bound to the top level.
// Depends on lbgc_pkg.
`default_nettype none
module lbgc_checker
  import lbgc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);
  // Result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  // A sample never raises a result
  a_sample: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid) else $error("spurious result");
  // Step accepted blocks further input
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready) else $error("input taken during step");
  // Turning results carry no linear speed
  a_turn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25] |-> m_tdata[10:0] == 11'd0) else $error("linear while turning");
endmodule

bind laser_bump_and_go_controller_unit lbgc_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
